// ===== sv/lwbc_pkg.sv =====
// Package for the LRU write-back block cache directory.
// Holds field widths, command and state codes, and the cell control structs.
// No dependencies; every other file imports it.
package lwbc_pkg;

    // Field widths fixed by the item format.
    localparam int CMD_W     = 2;
    localparam int FILE_W    = 8;
    localparam int BLOCK_W   = 52;
    localparam int SLOT_W    = 6;
    localparam int CFG_W     = 7;
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 72;

    // Default number of slots and reset value of the capacity register.
    localparam int               ENTRIES_DEF = 16;
    localparam logic [CFG_W-1:0] CAP_RESET   = 7'd16;

    // Command codes carried in s_tuser.
    typedef enum logic [CMD_W-1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_MARK  = 2'd2,
        CMD_SYNC  = 2'd3
    } cmd_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_SYNC = 2'd2
    } state_t;

    // Operation broadcast to every cell; tag and dirty writes apply to the selected cell.
    typedef struct packed {
        logic load_tag;   // selected cell takes the broadcast tag and becomes valid
        logic dirty_wr;   // selected cell writes dirty_val into its dirty bit
        logic dirty_val;
        logic touch_en;   // move the selected cell to most recent
        logic pend_load;  // all cells latch "dirty and of the sync file"
        logic pend_clr;   // selected cell drops its pending mark
    } cell_op_t;

    // Status flags each cell reports back.
    typedef struct packed {
        logic valid;
        logic dirty;
        logic file_eq;
        logic match;
        logic pend;
        logic at_probe;
    } cell_stat_t;

endpackage

// ===== sv/lwbc_cell.sv =====
// One directory slot: tag, valid, dirty, recency rank and sync pending mark.
// Compares its tag and rank against broadcast values and applies broadcast operations.
// Depends on lwbc_pkg.
module lwbc_cell import lwbc_pkg::*; #(
    parameter int ENTRIES  = ENTRIES_DEF,
    parameter int CELL_IDX = 0
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  cell_op_t                     op,
    input  logic                         sel,
    input  logic [FILE_W-1:0]            tag_file,
    input  logic [BLOCK_W-1:0]           tag_block,
    input  logic [$clog2(ENTRIES)-1:0]   touch_rank,
    input  logic [$clog2(ENTRIES)-1:0]   probe_rank,
    output cell_stat_t                   stat,
    output logic [FILE_W-1:0]            file,
    output logic [BLOCK_W-1:0]           block,
    output logic [$clog2(ENTRIES)-1:0]   rank
);

    localparam int RANK_W = $clog2(ENTRIES);

    logic              valid_reg, valid_next;
    logic              dirty_reg, dirty_next;
    logic              pend_reg, pend_next;
    logic [RANK_W-1:0] rank_reg, rank_next;
    logic [FILE_W-1:0]  file_reg;
    logic [BLOCK_W-1:0] block_reg;
    logic               file_eq;

    assign file_eq = (file_reg == tag_file);

    // Status toward the controller.
    always_comb begin
        stat.valid    = valid_reg;
        stat.dirty    = dirty_reg;
        stat.file_eq  = file_eq;
        stat.match    = valid_reg && file_eq && (block_reg == tag_block);
        stat.pend     = pend_reg;
        stat.at_probe = (rank_reg == probe_rank);
    end

    assign file  = file_reg;
    assign block = block_reg;
    assign rank  = rank_reg;

    // Next values of the control bits and the rank.
    always_comb begin
        valid_next = valid_reg;
        dirty_next = dirty_reg;
        pend_next  = pend_reg;
        rank_next  = rank_reg;
        if (sel && op.load_tag) begin
            valid_next = 1'b1;
        end
        if (sel && op.dirty_wr) begin
            dirty_next = op.dirty_val;
        end
        if (op.pend_load) begin
            pend_next = valid_reg && dirty_reg && file_eq;
        end else if (sel && op.pend_clr) begin
            pend_next = 1'b0;
        end
        // Touch: the chosen slot goes to rank zero, every more recent slot ages by one.
        if (op.touch_en) begin
            if (sel) begin
                rank_next = '0;
            end else if (rank_reg < touch_rank) begin
                rank_next = rank_reg + 1'b1;
            end
        end
    end

    // Control state, cleared by reset; ranks start equal to the slot index.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            dirty_reg <= 1'b0;
            pend_reg  <= 1'b0;
            rank_reg  <= RANK_W'(CELL_IDX);
        end else begin
            valid_reg <= valid_next;
            dirty_reg <= dirty_next;
            pend_reg  <= pend_next;
            rank_reg  <= rank_next;
        end
    end

    // Tag storage, meaningful only while the slot is valid.
    always_ff @(posedge aclk) begin
        if (sel && op.load_tag) begin
            file_reg  <= tag_file;
            block_reg <= tag_block;
        end
    end

endmodule

// ===== sv/lru_writeback_block_cache_directory_core.sv =====
// Top level of the LRU write-back block cache directory: a row of slot cells and
// the controller that runs accesses, mark-dirty and the sync walk.
// Depends on lwbc_pkg and lwbc_cell.
//
//  Channel  | Direction | Handshake              | Payload
//  ---------+-----------+------------------------+----------------------------------------
//  s_       | in        | s_tvalid / s_tready    | s_tuser: cmd; s_tdata: file_id, block
//  m_       | out       | m_tvalid / m_tready    | m_tdata: result fields; m_tlast: last
//  cfg_     | in        | cfg_we (no wait)       | cfg_wdata: capacity
//
// A read, write or mark-dirty item is first registered; then every cell compares its
// tag and the chosen cell is updated in place once the output register is free.
// A sync item then marks the dirty slots of its file; the walk visits one rank per cycle
// in most-to-least-recent order, holding on a pending rank while the output is busy.
// Reset is synchronous: all slots become invalid and clean, ranks equal slot indexes,
// capacity is 16; there is no clearing pass.
// A result waits in the output register while m_tready is low; the next item is still
// taken, and its execute cycle holds until the output register is free.
module lru_writeback_block_cache_directory_core import lwbc_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input items.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] file_id, [59:8] block_number, rest zero
    input  logic [CMD_W-1:0]     s_tuser,   // [1:0] cmd
    // Result items.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [0] hit, [6:1] slot, [7] fill_needed,
                                            // [8] writeback_valid, [16:9] writeback_file,
                                            // [68:17] writeback_block, rest zero
    output logic                 m_tlast,   // last
    // Capacity register.
    input  logic                 cfg_we,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    localparam int RANK_W = $clog2(ENTRIES);
    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);

    // Controller registers.
    state_t             state_reg, state_next;
    cmd_t               cmd_reg;
    logic [FILE_W-1:0]  file_reg;
    logic [BLOCK_W-1:0] block_reg;
    logic [CNT_W-1:0]   used_reg, used_next;
    logic [RANK_W-1:0]  scan_reg, scan_next;
    logic [CFG_W-1:0]   cap_reg;

    // Output register.
    logic               m_tvalid_reg, m_tvalid_next;
    logic               o_hit_reg, o_hit_next;
    logic [SLOT_W-1:0]  o_slot_reg, o_slot_next;
    logic               o_fill_reg, o_fill_next;
    logic               o_wbv_reg, o_wbv_next;
    logic [FILE_W-1:0]  o_wbf_reg, o_wbf_next;
    logic [BLOCK_W-1:0] o_wbb_reg, o_wbb_next;
    logic               o_last_reg, o_last_next;
    logic               out_load;

    // Cell row signals.
    cell_op_t           op;
    logic [ENTRIES-1:0] sel_vec;
    logic [RANK_W-1:0]  touch_rank;
    logic [RANK_W-1:0]  probe_rank;
    cell_stat_t         cell_stat  [ENTRIES];
    logic [FILE_W-1:0]  cell_file  [ENTRIES];
    logic [BLOCK_W-1:0] cell_block [ENTRIES];
    logic [RANK_W-1:0]  cell_rank  [ENTRIES];

    // Reductions over the row.
    logic [ENTRIES-1:0] match_vec, probe_vec, pend_vec, syncable_vec, free_vec;
    logic               hit_any, sync_any, cur_pend, pend_others;
    logic [IDX_W-1:0]   sel_idx;
    logic [FILE_W-1:0]  sel_file;
    logic [BLOCK_W-1:0] sel_block;
    logic [RANK_W-1:0]  sel_rank;
    logic               sel_dirty;
    logic [CFG_W-1:0]   cap_eff;
    logic               full;
    logic               out_free;
    logic               is_access;

    // Row of slot cells.
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lwbc_cell #(
            .ENTRIES  (ENTRIES),
            .CELL_IDX (g)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .op         (op),
            .sel        (sel_vec[g]),
            .tag_file   (file_reg),
            .tag_block  (block_reg),
            .touch_rank (touch_rank),
            .probe_rank (probe_rank),
            .stat       (cell_stat[g]),
            .file       (cell_file[g]),
            .block      (cell_block[g]),
            .rank       (cell_rank[g])
        );
        assign match_vec[g]    = cell_stat[g].match;
        assign probe_vec[g]    = cell_stat[g].at_probe;
        assign pend_vec[g]     = cell_stat[g].pend;
        assign syncable_vec[g] = cell_stat[g].valid && cell_stat[g].dirty
                                 && cell_stat[g].file_eq;
        // Slots fill in index order and never empty, so the free slot is at used_count.
        assign free_vec[g]     = (CNT_W'(g) == used_reg);
    end

    // Shared conditions.
    assign hit_any     = |match_vec;
    assign sync_any    = |syncable_vec;
    assign cur_pend    = |(probe_vec & pend_vec);
    assign pend_others = |(pend_vec & ~probe_vec);
    assign out_free    = !m_tvalid_reg || m_tready;
    assign is_access   = (cmd_reg == CMD_READ) || (cmd_reg == CMD_WRITE);

    // Effective capacity: zero acts as one, values above the slot count clamp to it.
    always_comb begin
        if (cap_reg == '0) begin
            cap_eff = CFG_W'(1);
        end else if (cap_reg > CFG_W'(ENTRIES)) begin
            cap_eff = CFG_W'(ENTRIES);
        end else begin
            cap_eff = cap_reg;
        end
    end
    assign full = (CFG_W'(used_reg) >= cap_eff);

    // Valid slots hold ranks 0 .. used-1, so the LRU victim has rank used-1;
    // during sync the probe walks the ranks instead.
    assign probe_rank = (state_reg == ST_SYNC) ? scan_reg : RANK_W'(used_reg - 1'b1);

    // Chosen cell: the hit, else the victim or free slot; during sync the scanned rank.
    always_comb begin
        if (state_reg == ST_SYNC) begin
            sel_vec = probe_vec;
        end else if (hit_any) begin
            sel_vec = match_vec;
        end else if (full) begin
            sel_vec = probe_vec;
        end else begin
            sel_vec = free_vec;
        end
    end

    // Read-out of the chosen cell through a one-hot OR mux.
    always_comb begin
        sel_idx   = '0;
        sel_file  = '0;
        sel_block = '0;
        sel_rank  = '0;
        sel_dirty = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (sel_vec[i]) begin
                sel_idx   = sel_idx | IDX_W'(i);
                sel_file  = sel_file | cell_file[i];
                sel_block = sel_block | cell_block[i];
                sel_rank  = sel_rank | cell_rank[i];
                sel_dirty = sel_dirty | cell_stat[i].dirty;
            end
        end
    end
    assign touch_rank = sel_rank;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (cmd_reg == CMD_SYNC && sync_any) begin
                    state_next = ST_SYNC;
                end else if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SYNC: begin
                if (cur_pend && out_free && !pend_others) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the controller: cell operation, result values, counters.
    always_comb begin
        s_tready    = 1'b0;
        op          = '0;
        out_load    = 1'b0;
        o_hit_next  = 1'b0;
        o_slot_next = '0;
        o_fill_next = 1'b0;
        o_wbv_next  = 1'b0;
        o_wbf_next  = '0;
        o_wbb_next  = '0;
        o_last_next = 1'b1;
        used_next   = used_reg;
        scan_next   = scan_reg;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_EXEC: begin
                if (cmd_reg == CMD_SYNC) begin
                    // Mark the dirty slots of the file, or report that there are none.
                    scan_next = '0;
                    if (sync_any) begin
                        op.pend_load = 1'b1;
                    end else if (out_free) begin
                        out_load = 1'b1;
                    end
                end else if (out_free) begin
                    out_load = 1'b1;
                    if (hit_any) begin
                        o_hit_next   = 1'b1;
                        o_slot_next  = SLOT_W'(sel_idx);
                        op.touch_en  = is_access;
                        op.dirty_wr  = (cmd_reg != CMD_READ);
                        op.dirty_val = 1'b1;
                    end else if (is_access) begin
                        // Miss: refill a free slot or the LRU victim.
                        o_slot_next  = SLOT_W'(sel_idx);
                        o_fill_next  = 1'b1;
                        op.load_tag  = 1'b1;
                        op.dirty_wr  = 1'b1;
                        op.dirty_val = (cmd_reg == CMD_WRITE);
                        op.touch_en  = 1'b1;
                        if (full) begin
                            o_wbv_next = sel_dirty;
                            o_wbf_next = sel_dirty ? sel_file : '0;
                            o_wbb_next = sel_dirty ? sel_block : '0;
                        end else begin
                            used_next = used_reg + 1'b1;
                        end
                    end
                end
            end
            ST_SYNC: begin
                // One rank a cycle; a pending slot waits for a free output, then is reported and cleaned.
                if (cur_pend) begin
                    if (out_free) begin
                        out_load     = 1'b1;
                        o_slot_next  = SLOT_W'(sel_idx);
                        o_wbv_next   = 1'b1;
                        o_wbf_next   = sel_file;
                        o_wbb_next   = sel_block;
                        o_last_next  = !pend_others;
                        op.dirty_wr  = 1'b1;
                        op.dirty_val = 1'b0;
                        op.pend_clr  = 1'b1;
                        scan_next    = scan_reg + 1'b1;
                    end
                end else begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Output valid follows loads and consumption.
    always_comb begin
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            used_reg     <= '0;
            scan_reg     <= '0;
            cap_reg      <= CAP_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            scan_reg     <= scan_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    // Input item register.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_reg   <= cmd_t'(s_tuser);
            file_reg  <= s_tdata[FILE_W-1:0];
            block_reg <= s_tdata[FILE_W +: BLOCK_W];
        end
    end

    // Result payload register.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            o_hit_reg  <= o_hit_next;
            o_slot_reg <= o_slot_next;
            o_fill_reg <= o_fill_next;
            o_wbv_reg  <= o_wbv_next;
            o_wbf_reg  <= o_wbf_next;
            o_wbb_reg  <= o_wbb_next;
            o_last_reg <= o_last_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = {3'b000, o_wbb_reg, o_wbf_reg, o_wbv_reg, o_fill_reg,
                       o_slot_reg, o_hit_reg};

    // Tags stay unique, so at most one cell matches.
    a_match_unique: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(match_vec))
        else $error("more than one slot matches the tag");

    // Ranks form a permutation, so the scanned rank is held by exactly one cell.
    a_probe_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SYNC) |-> $onehot(probe_vec))
        else $error("sync scan rank not held by exactly one slot");

    // An accepted item puts the controller in the execute state in the next cycle.
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_EXEC))
        else $error("accepted item not executed");

    // The used count never exceeds the slot count.
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= CNT_W'(ENTRIES))
        else $error("used count above slot count");

endmodule

// ===== bench/lru_writeback_block_cache_directory_core_test.sv =====
// Self-checking bench for the LRU write-back block cache directory core.
// Predicts every result item from its own copy of the directory state and compares them.
// Depends on lwbc_pkg and lru_writeback_block_cache_directory_core.
`timescale 1ns / 100ps

module lru_writeback_block_cache_directory_core_test;
    import lwbc_pkg::*;

    localparam int ENTRIES = ENTRIES_DEF;

    // One access, mark-dirty or sync request.
    typedef struct packed {
        cmd_t               cmd;
        logic [FILE_W-1:0]  file;
        logic [BLOCK_W-1:0] block;
    } dir_req_t;

    // One result item as carried by m_tdata and m_tlast.
    typedef struct packed {
        logic               hit;
        logic [SLOT_W-1:0]  slot;
        logic               fill;
        logic               wb_valid;
        logic [FILE_W-1:0]  wb_file;
        logic [BLOCK_W-1:0] wb_block;
        logic               last;
    } dir_resp_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [CMD_W-1:0]     s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 cfg_we    = 1'b0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    lru_writeback_block_cache_directory_core #(
        .ENTRIES (ENTRIES)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #4 aclk = ~aclk;

    // Predicted copy of the directory.
    logic [BLOCK_W-1:0] dir_block [ENTRIES];
    logic [FILE_W-1:0]  dir_file  [ENTRIES];
    logic               dir_valid [ENTRIES];
    logic               dir_dirty [ENTRIES];
    int                 dir_rank  [ENTRIES];
    int                 dir_used;
    logic [CFG_W-1:0]   dir_capacity;

    dir_req_t  pending_reqs[$];
    dir_resp_t expected_results[$];
    dir_req_t  cur_req;
    int        errors = 0;

    // Tag pool for the well-formed part of a random phase.
    logic [FILE_W-1:0]  pool_file  [3];
    logic [BLOCK_W-1:0] pool_block [12];

    function automatic void reset_directory();
        for (int i = 0; i < ENTRIES; i++) begin
            dir_block[i] = '0;
            dir_file[i]  = '0;
            dir_valid[i] = 1'b0;
            dir_dirty[i] = 1'b0;
            dir_rank[i]  = i;
        end
        dir_used     = 0;
        dir_capacity = CAP_RESET;
    endfunction

    // Move a slot to most recent; every slot that was more recent ages by one.
    function automatic void touch_slot(int s);
        int old_rank;
        old_rank = dir_rank[s];
        for (int i = 0; i < ENTRIES; i++) begin
            if (dir_rank[i] < old_rank) dir_rank[i]++;
        end
        dir_rank[s] = 0;
    endfunction

    // The tag includes the file id, so the same block of two files never matches.
    function automatic int find_slot(logic [FILE_W-1:0] f, logic [BLOCK_W-1:0] b);
        for (int i = 0; i < ENTRIES; i++) begin
            if (dir_valid[i] && dir_file[i] == f && dir_block[i] == b) return i;
        end
        return -1;
    endfunction

    function automatic int effective_capacity();
        if (dir_capacity == 0) return 1;
        if (dir_capacity > ENTRIES) return ENTRIES;
        return int'(dir_capacity);
    endfunction

    // Work out the result items of one accepted request and update the directory.
    task automatic predict_directory(input dir_req_t rq);
        int        s;
        int        victim;
        int        best;
        dir_resp_t r;
        dir_resp_t walk[$];
        r = '0;
        s = find_slot(rq.file, rq.block);
        case (rq.cmd)
            CMD_READ, CMD_WRITE: begin
                if (s >= 0) begin
                    touch_slot(s);
                    if (rq.cmd == CMD_WRITE) dir_dirty[s] = 1'b1;
                    r.hit  = 1'b1;
                    r.slot = SLOT_W'(s);
                end else begin
                    // Full (or over-full after lowering capacity): evict the least recent.
                    victim = -1;
                    best   = -1;
                    if (dir_used >= effective_capacity()) begin
                        for (int i = 0; i < ENTRIES; i++) begin
                            if (dir_valid[i] && dir_rank[i] > best) begin
                                best   = dir_rank[i];
                                victim = i;
                            end
                        end
                    end
                    if (victim >= 0) begin
                        if (dir_dirty[victim]) begin
                            r.wb_valid = 1'b1;
                            r.wb_file  = dir_file[victim];
                            r.wb_block = dir_block[victim];
                        end
                        s = victim;
                    end else begin
                        for (int i = 0; i < ENTRIES; i++) begin
                            if (!dir_valid[i] && s < 0) s = i;
                        end
                        if (s < 0) s = 0;
                        else dir_used++;
                    end
                    dir_valid[s] = 1'b1;
                    dir_file[s]  = rq.file;
                    dir_block[s] = rq.block;
                    dir_dirty[s] = (rq.cmd == CMD_WRITE);
                    touch_slot(s);
                    r.slot = SLOT_W'(s);
                    r.fill = 1'b1;
                end
                r.last = 1'b1;
                expected_results.push_back(r);
            end
            CMD_MARK: begin
                if (s >= 0) begin
                    dir_dirty[s] = 1'b1;
                    r.hit  = 1'b1;
                    r.slot = SLOT_W'(s);
                end
                r.last = 1'b1;
                expected_results.push_back(r);
            end
            default: begin
                // Sync walks ranks from most to least recent.
                for (int rk = 0; rk < ENTRIES; rk++) begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (dir_rank[i] == rk && dir_valid[i] && dir_dirty[i]
                                && dir_file[i] == rq.file) begin
                            r          = '0;
                            r.slot     = SLOT_W'(i);
                            r.wb_valid = 1'b1;
                            r.wb_file  = dir_file[i];
                            r.wb_block = dir_block[i];
                            walk.push_back(r);
                            dir_dirty[i] = 1'b0;
                        end
                    end
                end
                if (walk.size() == 0) begin
                    r      = '0;
                    r.last = 1'b1;
                    expected_results.push_back(r);
                end else begin
                    for (int k = 0; k < walk.size(); k++) begin
                        r      = walk[k];
                        r.last = (k == walk.size() - 1);
                        expected_results.push_back(r);
                    end
                end
            end
        endcase
    endtask

    function automatic logic [BLOCK_W-1:0] rand_block();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[BLOCK_W-1:0];
    endfunction

    task automatic add_req(cmd_t c, logic [FILE_W-1:0] f, logic [BLOCK_W-1:0] b);
        dir_req_t rq;
        rq.cmd   = c;
        rq.file  = f;
        rq.block = b;
        pending_reqs.push_back(rq);
    endtask

    // Mostly accesses to a small tag pool so that hits, evictions and syncs with
    // several writebacks happen; the rest is fully random noise.
    task automatic add_random_phase(int n);
        int roll;
        int k;
        for (int i = 0; i < 3; i++) pool_file[i] = FILE_W'($urandom);
        for (int i = 0; i < 12; i++) pool_block[i] = rand_block();
        for (int j = 0; j < n; j++) begin
            roll = $urandom_range(0, 99);
            k    = $urandom_range(0, 23);
            if (roll < 12) begin
                add_req(cmd_t'($urandom_range(0, 3)), FILE_W'($urandom), rand_block());
            end else if (roll < 43) begin
                add_req(CMD_READ, pool_file[k / 12], pool_block[k % 12]);
            end else if (roll < 70) begin
                add_req(CMD_WRITE, pool_file[k / 12], pool_block[k % 12]);
            end else if (roll < 83) begin
                add_req(CMD_MARK, pool_file[k / 12], pool_block[k % 12]);
            end else begin
                add_req(CMD_SYNC, pool_file[$urandom_range(0, 2)], rand_block());
            end
        end
    endtask

    // Let the driver send everything and wait for all results to come back.
    task automatic drain();
        @(negedge aclk);
        while (pending_reqs.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Only called while the block is idle.
    task automatic write_capacity(logic [CFG_W-1:0] v);
        @(posedge aclk);
        cfg_we       <= 1'b1;
        cfg_wdata    <= v;
        dir_capacity  = v;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic report_field(string field, logic [63:0] want, logic [63:0] got);
        $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
        errors++;
    endtask

    // Sender: bursts of items with random gaps; valid stays up until the item is taken.
    int gap_left   = 0;
    int burst_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            gap_left    = 0;
            burst_left  = 0;
        end else begin
            if (s_tvalid && s_tready) predict_directory(cur_req);
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    cur_req   = pending_reqs.pop_front();
                    s_tdata  <= {{(S_TDATA_W - BLOCK_W - FILE_W){1'b0}}, cur_req.block,
                                 cur_req.file};
                    s_tuser  <= cur_req.cmd;
                    s_tvalid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 15);
                        gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: switches between always ready, random stalls and a periodic stall.
    int stall_mode = 0;
    int mode_left  = 0;
    int stall_cyc  = 0;

    always @(posedge aclk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 200);
        end
        mode_left--;
        stall_cyc++;
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= (stall_cyc % 4 == 0);
            default: m_tready <= ($urandom_range(0, 99) < 85);
        endcase
    end

    // Compare each accepted result item with the oldest prediction.
    always @(posedge aclk) begin : result_monitor
        dir_resp_t got;
        dir_resp_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.hit      = m_tdata[0];
            got.slot     = m_tdata[6:1];
            got.fill     = m_tdata[7];
            got.wb_valid = m_tdata[8];
            got.wb_file  = m_tdata[16:9];
            got.wb_block = m_tdata[68:17];
            got.last     = m_tlast;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result item: expected none, actual %h last %b",
                         $time, m_tdata, m_tlast);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (got.hit !== want.hit)
                    report_field("hit", 64'(want.hit), 64'(got.hit));
                if (got.slot !== want.slot)
                    report_field("slot", 64'(want.slot), 64'(got.slot));
                if (got.fill !== want.fill)
                    report_field("fill_needed", 64'(want.fill), 64'(got.fill));
                if (got.wb_valid !== want.wb_valid)
                    report_field("writeback_valid", 64'(want.wb_valid), 64'(got.wb_valid));
                if (got.wb_file !== want.wb_file)
                    report_field("writeback_file", 64'(want.wb_file), 64'(got.wb_file));
                if (got.wb_block !== want.wb_block)
                    report_field("writeback_block", 64'(want.wb_block), 64'(got.wb_block));
                if (got.last !== want.last)
                    report_field("last", 64'(want.last), 64'(got.last));
            end
        end
    end

    // Test sequence: directed cases, then random phases under several capacities.
    logic [CFG_W-1:0] phase_caps [8] = '{7'd127, 7'd3, 7'd0, 7'd12, 7'd64, 7'd5, 7'd16, 7'd2};
    logic [BLOCK_W-1:0] max_block = {BLOCK_W{1'b1}};

    initial begin
        reset_directory();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Misses into free slots, hits, and the same block under two files.
        @(negedge aclk);
        add_req(CMD_READ, 8'd0, '0);
        add_req(CMD_WRITE, 8'hFF, max_block);
        add_req(CMD_READ, 8'hFF, max_block);
        add_req(CMD_READ, 8'd0, max_block);
        add_req(CMD_MARK, 8'd0, '0);
        add_req(CMD_MARK, 8'd1, 52'd7);
        add_req(CMD_WRITE, 8'hFF, '0);
        // Sync with two writebacks, again with nothing left to write back, then for file 0.
        add_req(CMD_SYNC, 8'hFF, '0);
        add_req(CMD_SYNC, 8'hFF, max_block);
        add_req(CMD_SYNC, 8'd0, '0);
        add_req(CMD_WRITE, 8'd0, '0);
        add_req(CMD_READ, 8'd0, '0);
        drain();

        // Capacity below the used count: every miss evicts, dirty victims write back.
        write_capacity(7'd1);
        @(negedge aclk);
        add_req(CMD_READ, 8'd9, 52'd5);
        for (int i = 1; i < 5; i++) add_req(CMD_WRITE, 8'd9, 52'(i));
        add_req(CMD_READ, 8'd9, 52'd4);
        add_req(CMD_SYNC, 8'd9, '0);
        drain();

        // Capacity zero behaves as one.
        write_capacity(7'd0);
        @(negedge aclk);
        add_req(CMD_WRITE, 8'd8, 52'd1);
        add_req(CMD_WRITE, 8'd8, 52'd2);
        add_req(CMD_MARK, 8'd8, 52'd1);
        drain();

        for (int p = 0; p < 8; p++) begin
            write_capacity(phase_caps[p]);
            @(negedge aclk);
            add_random_phase(46);
            drain();
        end

        repeat (ENTRIES + 8) @(posedge aclk);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #4000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
